FILE: hw/rtl/kef_pkg.sv
// shared types and constants for the key press event unit
`timescale 1ns / 1ps

package kef_pkg;

    localparam int KEY_W   = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_OFS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_REL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_REL    = 3'd4;

    localparam logic [KEY_W-1:0] RST_DEBOUNCE   = 8'd2;
    localparam logic [KEY_W-1:0] RST_LONG_PRESS = 8'd100;
    localparam logic [KEY_W-1:0] RST_PRESS_OFS  = 8'd0;
    localparam logic [KEY_W-1:0] RST_SHORT_REL  = 8'd64;
    localparam logic [KEY_W-1:0] RST_LONG_REL   = 8'd128;

    localparam logic [KEY_W-1:0] NO_KEY     = 8'h00;
    localparam logic [KEY_W-1:0] EMPTY_CODE = 8'hFF;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_LONG   = 2'd1,
        PH_REPEAT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              push;
        logic [KEY_W-1:0]  code;
        t_phase            phase;
    } t_cmd;

endpackage

FILE: hw/rtl/key_press_event_fsm_with_fifo_unit.sv
// top level of the key press event unit
`timescale 1ns / 1ps

// Takes one request per clock (scan tick, pop or flush) and returns exactly one
// response per request, in order. Sustained rate is one request per cycle while
// the output is not stalled: the front end classifies the request and runs the
// debounce / long press state machine in the accept cycle, a two entry command
// queue hands it to the event queue, whose single memory write port and
// registered read port produce the response register. Input ready drops only
// when the command queue is full under output backpressure. Config writes go
// straight to the front end registers and are expected while idle.

module key_press_event_fsm_with_fifo_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_sample[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_code, queue_count, press_phase, dropped_oldest
    output logic [0:0]  m_axis_tuser    // read_valid
);

    kef_pkg::t_cmd front_cmd, q_cmd;
    logic          in_fire, q_full, q_valid, back_ready, q_pop;
    logic [kef_pkg::KEY_W-1:0]   read_code;
    logic                        read_valid, dropped_oldest;
    logic [kef_pkg::COUNT_W-1:0] queue_count;
    logic [1:0]                  press_phase;

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign q_pop         = q_valid && back_ready;

    kef_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (in_fire),
        .i_kind     (s_axis_tuser),
        .i_sample   (s_axis_tdata),
        .o_cmd      (front_cmd)
    );

    kef_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    kef_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_cmd            (q_cmd),
        .o_ready          (back_ready),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_read_code      (read_code),
        .o_read_valid     (read_valid),
        .o_queue_count    (queue_count),
        .o_press_phase    (press_phase),
        .o_dropped_oldest (dropped_oldest)
    );

    assign m_axis_tdata = {dropped_oldest, press_phase, queue_count, read_code};
    assign m_axis_tuser = read_valid;

endmodule

FILE: hw/rtl/kef_front.sv
// front end: config registers, debounce and long press state machine
`timescale 1ns / 1ps

module kef_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kef_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kef_pkg::KEY_W-1:0]     i_cfg_data,
    input  logic                          i_fire,
    input  logic [kef_pkg::KIND_W-1:0]    i_kind,
    input  logic [kef_pkg::KEY_W-1:0]     i_sample,
    output kef_pkg::t_cmd                 o_cmd
);

    logic [kef_pkg::KEY_W-1:0] r_debounce, r_long_press, r_press_ofs, r_short_rel, r_long_rel;
    kef_pkg::t_phase           r_phase, n_phase;
    logic [kef_pkg::KEY_W-1:0] r_last_key, n_last_key;
    logic [kef_pkg::KEY_W-1:0] r_tick, n_tick;
    logic                      push;
    logic [kef_pkg::KEY_W-1:0] push_code;
    logic                      tick;

    assign tick = i_fire && (i_kind == kef_pkg::KIND_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= kef_pkg::RST_DEBOUNCE;
            r_long_press <= kef_pkg::RST_LONG_PRESS;
            r_press_ofs  <= kef_pkg::RST_PRESS_OFS;
            r_short_rel  <= kef_pkg::RST_SHORT_REL;
            r_long_rel   <= kef_pkg::RST_LONG_REL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kef_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                kef_pkg::CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                kef_pkg::CFG_PRESS_OFS:  r_press_ofs  <= i_cfg_data;
                kef_pkg::CFG_SHORT_REL:  r_short_rel  <= i_cfg_data;
                kef_pkg::CFG_LONG_REL:   r_long_rel   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_last_key = r_last_key;
        n_tick     = r_tick;
        if (tick) begin
            case (r_phase)
                kef_pkg::PH_WAIT: begin
                    if (i_sample == kef_pkg::NO_KEY || i_sample != r_last_key) begin
                        n_last_key = i_sample;
                        n_tick     = '0;
                    end else if (r_tick < r_debounce) begin
                        n_tick = r_tick + 8'd1;
                    end else begin
                        n_tick  = '0;
                        n_phase = kef_pkg::PH_LONG;
                    end
                end
                kef_pkg::PH_LONG: begin
                    if (i_sample == r_last_key) begin
                        if (r_tick < r_long_press) begin
                            n_tick = r_tick + 8'd1;
                        end else begin
                            n_tick  = '0;
                            n_phase = kef_pkg::PH_REPEAT;
                        end
                    end else begin
                        n_tick  = '0;
                        n_phase = kef_pkg::PH_WAIT;
                    end
                end
                kef_pkg::PH_REPEAT: begin
                    if (i_sample != r_last_key) begin
                        n_tick  = '0;
                        n_phase = kef_pkg::PH_WAIT;
                    end
                end
                default: begin
                    n_phase = kef_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // event generation
    always_comb begin
        push      = 1'b0;
        push_code = r_last_key + r_press_ofs;
        if (tick) begin
            case (r_phase)
                kef_pkg::PH_WAIT: begin
                    push = (i_sample != kef_pkg::NO_KEY) && (i_sample == r_last_key)
                           && !(r_tick < r_debounce);
                end
                kef_pkg::PH_LONG: begin
                    push      = (i_sample == kef_pkg::NO_KEY) && (r_last_key != kef_pkg::NO_KEY);
                    push_code = r_last_key + r_short_rel;
                end
                kef_pkg::PH_REPEAT: begin
                    push      = (i_sample == kef_pkg::NO_KEY) && (r_last_key != kef_pkg::NO_KEY);
                    push_code = r_last_key + r_long_rel;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= kef_pkg::PH_WAIT;
            r_last_key <= '0;
            r_tick     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_last_key <= n_last_key;
            r_tick     <= n_tick;
        end
    end

    assign o_cmd.kind  = i_kind;
    assign o_cmd.push  = push;
    assign o_cmd.code  = push_code;
    assign o_cmd.phase = n_phase;

endmodule

FILE: hw/rtl/kef_cmdq.sv
// two entry command queue between front end and event queue
`timescale 1ns / 1ps

module kef_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kef_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output kef_pkg::t_cmd o_cmd
);

    kef_pkg::t_cmd r_entry [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_entry[r_rd];

endmodule

FILE: hw/rtl/kef_back.sv
// back end: event ring queue and result register
`timescale 1ns / 1ps

module kef_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  kef_pkg::t_cmd                i_cmd,
    output logic                         o_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [kef_pkg::KEY_W-1:0]    o_read_code,
    output logic                         o_read_valid,
    output logic [kef_pkg::COUNT_W-1:0]  o_queue_count,
    output logic [1:0]                   o_press_phase,
    output logic                         o_dropped_oldest
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [kef_pkg::KEY_W-1:0] r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0]          r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      fire, do_push, do_pop, n_drop;
    logic [PTR_W-1:0]          wr_next, rd_next;
    logic [kef_pkg::KEY_W-1:0] r_rd_data;
    logic                      r_out_valid, r_hit, r_drop;
    logic [CNT_W-1:0]          r_out_count;
    logic [1:0]                r_phase;

    assign o_ready = !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;
    assign do_push = fire && (i_cmd.kind == kef_pkg::KIND_TICK) && i_cmd.push;
    assign do_pop  = fire && (i_cmd.kind == kef_pkg::KIND_POP) && (r_count != '0);
    assign wr_next = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
    assign rd_next = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_drop   = 1'b0;
        if (do_push) begin
            n_wr_ptr = wr_next;
            if (r_count < FULL_CNT) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_rd_ptr = wr_next;
                n_drop   = 1'b1;
            end
        end else if (do_pop) begin
            n_rd_ptr = rd_next;
            n_count  = r_count - CNT_W'(1);
        end else if (fire && i_cmd.kind == kef_pkg::KIND_FLUSH) begin
            n_wr_ptr = '0;
            n_rd_ptr = '0;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_cmd.code;
        end
        if (do_pop) begin
            r_rd_data <= r_store[r_rd_ptr];
        end
        if (fire) begin
            r_out_count <= n_count;
            r_phase     <= i_cmd.phase;
            r_drop      <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
                r_hit       <= do_pop;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_code      = r_hit ? r_rd_data : kef_pkg::EMPTY_CODE;
    assign o_read_valid     = r_hit;
    assign o_queue_count    = kef_pkg::COUNT_W'(r_out_count);
    assign o_press_phase    = r_phase;
    assign o_dropped_oldest = r_drop;

endmodule

FILE: hw/rtl/kef_checker.sv
// port level checks for the key press event unit
`timescale 1ns / 1ps

module kef_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("response valid right after reset");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'hFF)
        else $error("read code not 255 without a popped event");

    a_drop_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> !m_axis_tuser[0]
            && m_axis_tdata[14:13] == 2'd1 && m_axis_tdata[12:8] != 5'd0
            || m_axis_tvalid && m_axis_tdata[15] && !m_axis_tuser[0]
            && m_axis_tdata[14:13] == 2'd0)
        else $error("overwrite flagged on a response that cannot push");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled response changed");

endmodule

bind key_press_event_fsm_with_fifo_unit kef_checker u_kef_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
